/* design/nmea_sentence_checksum_check_defines.svh */
// ----------------------------------------------------------------------------
// NMEA checksum checker assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef NMEA_SENTENCE_CHECKSUM_CHECK_DEFINES_SVH
`define NMEA_SENTENCE_CHECKSUM_CHECK_DEFINES_SVH

// check a condition at every clock edge out of reset
`define NSCC_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// check a condition in the cycle after a trigger
`define NSCC_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

/* design/nscc_pkg.sv */
// ----------------------------------------------------------------------------
// NMEA checksum checker package
// Word types, character and register constants, hex digit decode.
// ----------------------------------------------------------------------------
`default_nettype none

package nscc_pkg;

	localparam logic [7:0] CHAR_STAR       = 8'h2A;
	localparam logic [7:0] CHAR_DOLLAR     = 8'h24;
	localparam logic [7:0] MIN_LENGTH_RST  = 8'd9;
	localparam logic [1:0] CHECKSUM_CHARS  = 2'd2;
	localparam logic [7:0] COUNT_MAX       = 8'd255;

	localparam int         APB_ADDR_W      = 3;
	localparam int         APB_DATA_W      = 32;
	localparam logic       REG_MIN_LENGTH  = 1'b0;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} sentence_t;

	typedef struct packed {
		logic [7:0] computed_checksum;
		logic [7:0] received_checksum;
		logic       checksum_valid;
		logic       no_checksum;
		logic       invalid_hex;
		logic       multiple_checksum;
		logic       too_short;
		logic       accepted;
	} report_t;

	// {bad, value}
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		logic [4:0] r;
		r = {1'b1, 4'h0};
		if (c >= 8'h30 && c <= 8'h39)
			r = {1'b0, c[3:0]};
		else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
			r = {1'b0, c[3:0] + 4'd9};
		return r;
	endfunction

endpackage

`default_nettype wire

/* design/nscc_cfg.sv */
// ----------------------------------------------------------------------------
// NMEA checksum checker configuration registers
// APB write and read of the minimum sentence length.
// ----------------------------------------------------------------------------
`default_nettype none

module nscc_cfg (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [nscc_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire logic [nscc_pkg::APB_DATA_W-1:0]   pwdata,
	output logic      [nscc_pkg::APB_DATA_W-1:0]   prdata,
	output logic                                   pready,
	output logic      [7:0]                        min_length
);

	logic [7:0] min_length_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready
		&& (paddr[nscc_pkg::APB_ADDR_W-1] == nscc_pkg::REG_MIN_LENGTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_length_q <= nscc_pkg::MIN_LENGTH_RST;
		end else if (wr_en) begin
			min_length_q <= pwdata[7:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[nscc_pkg::APB_ADDR_W-1] == nscc_pkg::REG_MIN_LENGTH)
			prdata[7:0] = min_length_q;
	end

	assign min_length = min_length_q;

endmodule

`default_nettype wire

/* design/nscc_core.sv */
// ----------------------------------------------------------------------------
// NMEA checksum checker sentence core
// Per-word update of XOR, checksum capture and length; report on last word.
// ----------------------------------------------------------------------------
`default_nettype none
`include "nmea_sentence_checksum_check_defines.svh"

module nscc_core (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire nscc_pkg::sentence_t  item,
	input  wire logic [7:0]           min_length,
	output nscc_pkg::report_t         report
);

	logic [7:0] acc_q, acc_n;
	logic       crc_act_q, crc_act_n;
	logic       cap_act_q, cap_act_n;
	logic       cap_conf_q, cap_conf_n;
	logic [1:0] cap_idx_q, cap_idx_n;
	logic [7:0] hex0_q, hex0_n, hex1_q, hex1_n;
	logic       multi_q, multi_n;
	logic [7:0] cnt_q, cnt_n;
	logic       is_star, is_dollar, present, bad_hex, valid, short_s;
	logic [4:0] hi, lo;
	logic [7:0] received;

	always_comb begin
		is_star   = (item.data_byte == nscc_pkg::CHAR_STAR);
		is_dollar = (item.data_byte == nscc_pkg::CHAR_DOLLAR);
		cnt_n     = (cnt_q == nscc_pkg::COUNT_MAX) ? cnt_q : cnt_q + 8'd1;

		cap_act_n  = cap_act_q;
		cap_conf_n = cap_conf_q;
		cap_idx_n  = cap_idx_q;
		hex0_n     = hex0_q;
		hex1_n     = hex1_q;
		multi_n    = multi_q;
		if (cap_act_q) begin
			if (cap_idx_q < nscc_pkg::CHECKSUM_CHARS) begin
				if (cap_idx_q[0])
					hex1_n = item.data_byte;
				else
					hex0_n = item.data_byte;
				cap_idx_n = cap_idx_q + 2'd1;
			end else begin
				cap_conf_n = 1'b1;
				cap_act_n  = 1'b0;
			end
		end
		if (is_star && !cap_conf_n) begin
			cap_act_n = 1'b1;
			cap_idx_n = 2'd0;
		end else if (is_star) begin
			multi_n = 1'b1;
		end

		crc_act_n = crc_act_q && !is_star;
		acc_n     = crc_act_n ? (acc_q ^ item.data_byte) : acc_q;
		if (is_dollar)
			crc_act_n = 1'b1;

		present  = cap_conf_n || (cap_act_n && cap_idx_n == nscc_pkg::CHECKSUM_CHARS);
		hi       = nscc_pkg::hex_nibble(hex0_n);
		lo       = nscc_pkg::hex_nibble(hex1_n);
		bad_hex  = present && (hi[4] || lo[4]);
		received = (present && !bad_hex) ? {hi[3:0], lo[3:0]} : 8'd0;
		valid    = present && !bad_hex && (received == acc_n);
		short_s  = cnt_n < min_length;

		report.computed_checksum = acc_n;
		report.received_checksum = received;
		report.checksum_valid    = valid;
		report.no_checksum       = !present;
		report.invalid_hex       = bad_hex;
		report.multiple_checksum = multi_n;
		report.too_short         = short_s;
		report.accepted          = valid && !short_s;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			crc_act_q  <= 1'b0;
			cap_act_q  <= 1'b0;
			cap_conf_q <= 1'b0;
			cap_idx_q  <= '0;
			hex0_q     <= '0;
			hex1_q     <= '0;
			multi_q    <= 1'b0;
			cnt_q      <= '0;
		end else if (en) begin
			if (item.last_byte) begin
				acc_q      <= '0;
				crc_act_q  <= 1'b0;
				cap_act_q  <= 1'b0;
				cap_conf_q <= 1'b0;
				cap_idx_q  <= '0;
				hex0_q     <= '0;
				hex1_q     <= '0;
				multi_q    <= 1'b0;
				cnt_q      <= '0;
			end else begin
				acc_q      <= acc_n;
				crc_act_q  <= crc_act_n;
				cap_act_q  <= cap_act_n;
				cap_conf_q <= cap_conf_n;
				cap_idx_q  <= cap_idx_n;
				hex0_q     <= hex0_n;
				hex1_q     <= hex1_n;
				multi_q    <= multi_n;
				cnt_q      <= cnt_n;
			end
		end
	end

	`NSCC_ASSERT_ALWAYS(a_cap_idx_range, cap_idx_q != 2'd3, "capture index out of range")
	`NSCC_ASSERT_ALWAYS(a_cap_excl, !(cap_act_q && cap_conf_q), "capture active after confirm")
	`NSCC_ASSERT_NEXT(a_last_clears, en && item.last_byte, cnt_q == 8'd0 && !multi_q,
		"sentence state not cleared after last word")

endmodule

`default_nettype wire

/* design/nmea_sentence_checksum_check.sv */
// ----------------------------------------------------------------------------
// NMEA sentence checksum checker
// Checks the XOR checksum of NMEA 0183 sentences, one byte per word.
// ----------------------------------------------------------------------------
// Takes one sentence byte per clock cycle with no gaps required, while the
// report channel does not stall. A byte is registered on entry, then the
// sentence state and the report are updated in one pass, and the report is
// registered for output when the last byte of a sentence is taken. Input and
// output registers decouple the channels; a stalled report blocks input only
// once the entry register is also full. min_length is set over APB at byte
// address 0 (reset 9) and should only be changed between sentences.
`default_nettype none

module nmea_sentence_checksum_check (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              sentence_valid,
	output logic                                   sentence_ready,
	input  wire nscc_pkg::sentence_t               sentence,
	output logic                                   report_valid,
	input  wire logic                              report_ready,
	output nscc_pkg::report_t                      report,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [nscc_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire logic [nscc_pkg::APB_DATA_W-1:0]   pwdata,
	output logic      [nscc_pkg::APB_DATA_W-1:0]   prdata,
	output logic                                   pready
);

	logic                valid_s1;
	nscc_pkg::sentence_t item_s1;
	logic                valid_s2;
	nscc_pkg::report_t   report_s2;
	nscc_pkg::report_t   report_c;
	logic [7:0]          min_length;
	logic                out_free;
	logic                take;

	assign out_free       = !valid_s2 || report_ready;
	assign take           = valid_s1 && out_free;
	assign sentence_ready = !valid_s1 || out_free;

	nscc_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.min_length (min_length)
	);

	nscc_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (take),
		.item       (item_s1),
		.min_length (min_length),
		.report     (report_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sentence_ready) begin
			valid_s1 <= sentence_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sentence_ready && sentence_valid) begin
			item_s1 <= sentence;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= take && item_s1.last_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (take && item_s1.last_byte) begin
			report_s2 <= report_c;
		end
	end

	assign report_valid = valid_s2;
	assign report       = report_s2;

endmodule

`default_nettype wire

/* tb/nmea_sentence_checksum_check_test.sv */
// ----------------------------------------------------------------------------
// NMEA sentence checksum checker testbench
// Sends framed sentences with random content, corrupted checksums and raw
// noise, and compares every report with a local model of the checker.
// min_length is changed over APB between phases, and both channels idle.
// ----------------------------------------------------------------------------

module nmea_sentence_checksum_check_test;

	timeunit 1ns;
	timeprecision 1ps;

	typedef enum int {
		SK_GOOD,
		SK_WRONG_SUM,
		SK_NO_TAIL,
		SK_NO_SUM,
		SK_BAD_HEX,
		SK_EXTRA_STAR,
		SK_SECOND_DOLLAR,
		SK_SHORT_SUM,
		SK_STAR_IN_SUM,
		SK_NOISE
	} sentence_kind_e;

	typedef enum logic [1:0] {
		RX_FREE,
		RX_CHOPPY,
		RX_SLOW
	} rx_mode_e;

	localparam logic [nscc_pkg::APB_ADDR_W-1:0] MIN_LENGTH_ADDR =
		{nscc_pkg::REG_MIN_LENGTH, 2'b00};

	logic                            clk;
	logic                            arst_n         = 1'b0;
	logic                            sentence_valid = 1'b0;
	logic                            sentence_ready;
	nscc_pkg::sentence_t             sentence       = '0;
	logic                            report_valid;
	logic                            report_ready   = 1'b0;
	nscc_pkg::report_t               report;
	logic                            psel           = 1'b0;
	logic                            penable        = 1'b0;
	logic                            pwrite         = 1'b0;
	logic [nscc_pkg::APB_ADDR_W-1:0] paddr          = '0;
	logic [nscc_pkg::APB_DATA_W-1:0] pwdata         = '0;
	logic [nscc_pkg::APB_DATA_W-1:0] prdata;
	logic                            pready;

	// checker model state
	logic [7:0] min_length_cfg = nscc_pkg::MIN_LENGTH_RST;
	logic [7:0] xor_acc        = '0;
	logic       xor_on         = 1'b0;
	logic       cap_on         = 1'b0;
	logic       cap_locked     = 1'b0;
	logic [1:0] cap_count      = '0;
	logic [7:0] cap_chars [2]  = '{8'h00, 8'h00};
	logic       star_again     = 1'b0;
	logic [7:0] length_count   = '0;

	nscc_pkg::report_t expected_reports [$];
	logic [7:0]        sentence_bytes [$];

	rx_mode_e    rx_mode    = RX_FREE;
	logic [15:0] rx_pattern = 16'hFFFF;
	int          rx_tick    = 0;
	bit          tx_gappy   = 1'b0;
	int          burst_left = 0;

	int error_count     = 0;
	int byte_total      = 0;
	int sentence_total  = 0;
	int reports_checked = 0;
	int accepted_seen   = 0;
	int settings_total  = 0;
	int pause_total     = 0;

	nmea_sentence_checksum_check i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.sentence_valid (sentence_valid),
		.sentence_ready (sentence_ready),
		.sentence       (sentence),
		.report_valid   (report_valid),
		.report_ready   (report_ready),
		.report         (report),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("nmea_sentence_checksum_check regression: fail");
		$finish;
	end

	function automatic logic [4:0] nibble_of(input logic [7:0] c);
		logic [7:0] d;
		d = 8'h00;
		if (c >= "0" && c <= "9") begin
			d = c - "0";
			return {1'b0, d[3:0]};
		end
		if (c >= "A" && c <= "F") begin
			d = c - "A" + 8'd10;
			return {1'b0, d[3:0]};
		end
		if (c >= "a" && c <= "f") begin
			d = c - "a" + 8'd10;
			return {1'b0, d[3:0]};
		end
		return 5'h10;
	endfunction

	function automatic void track_byte(input logic [7:0] b, input logic is_last);
		logic              present;
		logic              bad;
		logic [4:0]        hi;
		logic [4:0]        lo;
		nscc_pkg::report_t r;
		if (length_count != nscc_pkg::COUNT_MAX)
			length_count++;
		if (cap_on) begin
			if (cap_count < nscc_pkg::CHECKSUM_CHARS) begin
				cap_chars[cap_count[0]] = b;
				cap_count++;
			end else begin
				cap_locked = 1'b1;
				cap_on     = 1'b0;
			end
		end
		if (b == nscc_pkg::CHAR_STAR) begin
			if (!cap_locked) begin
				cap_on    = 1'b1;
				cap_count = '0;
			end else begin
				star_again = 1'b1;
			end
			xor_on = 1'b0;
		end
		if (xor_on)
			xor_acc ^= b;
		if (b == nscc_pkg::CHAR_DOLLAR)
			xor_on = 1'b1;
		if (!is_last)
			return;
		present = cap_locked || (cap_on && cap_count == nscc_pkg::CHECKSUM_CHARS);
		hi      = nibble_of(cap_chars[0]);
		lo      = nibble_of(cap_chars[1]);
		bad     = present && (hi[4] || lo[4]);
		r.computed_checksum = xor_acc;
		r.received_checksum = (present && !bad) ? {hi[3:0], lo[3:0]} : 8'h00;
		r.checksum_valid    = present && !bad && r.received_checksum == xor_acc;
		r.no_checksum       = !present;
		r.invalid_hex       = bad;
		r.multiple_checksum = star_again;
		r.too_short         = length_count < min_length_cfg;
		r.accepted          = r.checksum_valid && !r.too_short;
		expected_reports.push_back(r);
		xor_acc      = '0;
		xor_on       = 1'b0;
		cap_on       = 1'b0;
		cap_locked   = 1'b0;
		cap_count    = '0;
		cap_chars[0] = '0;
		cap_chars[1] = '0;
		star_again   = 1'b0;
		length_count = '0;
	endfunction

	task automatic report_mismatch(input string what);
		error_count++;
		$display("[%0t] mismatch after %0d reports: %s", $realtime, reports_checked, what);
	endtask

	task automatic compare_field(input string name, input logic [7:0] got,
			input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h expected %h", name, got, want));
	endtask

	task automatic compare_flag(input string name, input logic got, input logic want);
		if (got !== want)
			report_mismatch($sformatf("%s got %b expected %b", name, got, want));
	endtask

	task automatic check_report(input nscc_pkg::report_t got);
		nscc_pkg::report_t want;
		if (expected_reports.size() == 0) begin
			report_mismatch($sformatf("report %h with none expected", got));
			return;
		end
		want = expected_reports.pop_front();
		compare_field("computed_checksum", got.computed_checksum, want.computed_checksum);
		compare_field("received_checksum", got.received_checksum, want.received_checksum);
		compare_flag("checksum_valid", got.checksum_valid, want.checksum_valid);
		compare_flag("no_checksum", got.no_checksum, want.no_checksum);
		compare_flag("invalid_hex", got.invalid_hex, want.invalid_hex);
		compare_flag("multiple_checksum", got.multiple_checksum, want.multiple_checksum);
		compare_flag("too_short", got.too_short, want.too_short);
		compare_flag("accepted", got.accepted, want.accepted);
		reports_checked++;
		if (got.accepted === 1'b1)
			accepted_seen++;
	endtask

	always @(posedge clk) begin
		if (arst_n && report_valid && report_ready)
			check_report(report);
	end

	always @(posedge clk) begin
		rx_tick = rx_tick + 1;
		if (rx_tick % 48 == 0) begin
			if (rx_mode == RX_SLOW)
				rx_pattern = (16'($urandom) & 16'h1111) | 16'h0001;
			else
				rx_pattern = 16'($urandom) | 16'h0101;
		end else begin
			rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
		end
		report_ready <= (rx_mode == RX_FREE) || rx_pattern[0];
	end

	task automatic send_byte(input logic [7:0] value, input logic is_last);
		int gap;
		if (tx_gappy && burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap        = $urandom_range(0, 8);
			if (gap != 0) begin
				sentence_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left > 0)
			burst_left--;
		sentence_valid <= 1'b1;
		sentence       <= '{data_byte: value, last_byte: is_last};
		do @(posedge clk); while (!sentence_ready);
		track_byte(value, is_last);
		byte_total++;
	endtask

	task automatic send_sentence();
		foreach (sentence_bytes[i])
			send_byte(sentence_bytes[i], i == sentence_bytes.size() - 1);
		sentence_total++;
	endtask

	task automatic drain_reports();
		sentence_valid <= 1'b0;
		do @(posedge clk); while (expected_reports.size() != 0);
	endtask

	task automatic read_min_length();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= MIN_LENGTH_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[7:0] !== min_length_cfg)
			report_mismatch($sformatf("min_length read %h expected %h",
				prdata[7:0], min_length_cfg));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_min_length(input logic [7:0] value);
		drain_reports();
		repeat (8) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= MIN_LENGTH_ADDR;
		pwdata  <= nscc_pkg::APB_DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		min_length_cfg = value;
		settings_total++;
		read_min_length();
	endtask

	function automatic logic [7:0] printable_char();
		logic [7:0] c;
		do c = 8'($urandom_range(32, 126));
		while (c == nscc_pkg::CHAR_DOLLAR || c == nscc_pkg::CHAR_STAR);
		return c;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10)
			return "0" + 8'(n);
		return ($urandom_range(0, 1) ? "A" : "a") + 8'(n) - 8'd10;
	endfunction

	function automatic logic [7:0] non_hex_char();
		logic [7:0] c;
		logic [4:0] d;
		do begin
			c = 8'($urandom);
			d = nibble_of(c);
		end while (!d[4]);
		return c;
	endfunction

	function automatic void compose_sentence(input sentence_kind_e kind, input int body_len,
			input bit with_prefix);
		logic [7:0] sum;
		logic [7:0] c;
		logic [7:0] hi;
		logic [7:0] lo;
		sentence_bytes.delete();
		if (kind == SK_NOISE) begin
			repeat ($urandom_range(1, 40)) sentence_bytes.push_back(8'($urandom));
			return;
		end
		if (with_prefix && $urandom_range(0, 7) == 0)
			repeat ($urandom_range(1, 3)) sentence_bytes.push_back(printable_char());
		sentence_bytes.push_back(nscc_pkg::CHAR_DOLLAR);
		sum = 8'h00;
		for (int i = 0; i < body_len; i++) begin
			c = (kind == SK_SECOND_DOLLAR && i == body_len / 2) ? nscc_pkg::CHAR_DOLLAR
				: printable_char();
			sentence_bytes.push_back(c);
			sum ^= c;
		end
		if (kind == SK_NO_SUM) begin
			sentence_bytes.push_back("\r");
			sentence_bytes.push_back("\n");
			return;
		end
		if (kind == SK_WRONG_SUM)
			sum ^= 8'h01 << $urandom_range(0, 7);
		hi = hex_char(sum[7:4]);
		lo = hex_char(sum[3:0]);
		if (kind == SK_BAD_HEX) begin
			if ($urandom_range(0, 1))
				hi = non_hex_char();
			else
				lo = non_hex_char();
		end
		if (kind == SK_STAR_IN_SUM)
			hi = nscc_pkg::CHAR_STAR;
		sentence_bytes.push_back(nscc_pkg::CHAR_STAR);
		sentence_bytes.push_back(hi);
		if (kind == SK_SHORT_SUM)
			return;
		sentence_bytes.push_back(lo);
		if (kind == SK_NO_TAIL)
			return;
		if (kind == SK_EXTRA_STAR) begin
			sentence_bytes.push_back("\r");
			sentence_bytes.push_back(nscc_pkg::CHAR_STAR);
			sentence_bytes.push_back(hex_char(4'($urandom)));
			sentence_bytes.push_back(hex_char(4'($urandom)));
		end
		sentence_bytes.push_back("\r");
		sentence_bytes.push_back("\n");
	endfunction

	task automatic test_register_reset();
		read_min_length();
	endtask

	task automatic test_directed_sentences();
		tx_gappy = 1'b0;
		rx_mode <= RX_FREE;
		sentence_bytes = '{nscc_pkg::CHAR_DOLLAR, "A", "B", "A", "B", nscc_pkg::CHAR_STAR,
			"0", "0", "\n"};
		send_sentence();
		sentence_bytes = '{8'h00, nscc_pkg::CHAR_DOLLAR, 8'hFF, nscc_pkg::CHAR_STAR, "F"};
		send_sentence();
		sentence_bytes = '{nscc_pkg::CHAR_DOLLAR, "Q", nscc_pkg::CHAR_STAR, "G", "1", "\r",
			nscc_pkg::CHAR_STAR};
		send_sentence();
		sentence_bytes = '{nscc_pkg::CHAR_DOLLAR, nscc_pkg::CHAR_STAR, "1",
			nscc_pkg::CHAR_STAR, "5", "A"};
		send_sentence();
	endtask

	task automatic test_length_limits();
		int bodies [3] = '{248, 249, 294};
		tx_gappy = 1'b1;
		rx_mode <= RX_CHOPPY;
		set_min_length(8'd0);
		repeat (3) begin
			compose_sentence(SK_GOOD, $urandom_range(0, 20), 1'b1);
			send_sentence();
		end
		sentence_bytes = '{nscc_pkg::CHAR_STAR};
		send_sentence();
		set_min_length(8'd255);
		foreach (bodies[i]) begin
			compose_sentence(SK_GOOD, bodies[i], 1'b0);
			send_sentence();
		end
		set_min_length(8'd1);
		sentence_bytes = '{8'h0A};
		send_sentence();
		compose_sentence(SK_GOOD, $urandom_range(0, 10), 1'b0);
		send_sentence();
	endtask

	task automatic test_random_sentences();
		int             items;
		int             in_phase;
		int             pick;
		int             body_len;
		sentence_kind_e kind;
		items = 0;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					tx_gappy = 1'b0;
					rx_mode <= RX_FREE;
				end
				1: begin
					tx_gappy = 1'b1;
					rx_mode <= RX_CHOPPY;
				end
				2: begin
					tx_gappy = 1'b1;
					rx_mode <= RX_SLOW;
				end
				default: begin
					tx_gappy = 1'b0;
					rx_mode <= RX_SLOW;
				end
			endcase
			set_min_length(8'($urandom_range(0, 40)));
			in_phase = 0;
			while (items < (phase + 1) * 240) begin
				pick = $urandom_range(0, 99);
				if (pick < 50)
					kind = SK_GOOD;
				else if (pick < 58)
					kind = SK_WRONG_SUM;
				else if (pick < 63)
					kind = SK_NO_TAIL;
				else if (pick < 69)
					kind = SK_NO_SUM;
				else if (pick < 75)
					kind = SK_BAD_HEX;
				else if (pick < 81)
					kind = SK_EXTRA_STAR;
				else if (pick < 86)
					kind = SK_SECOND_DOLLAR;
				else if (pick < 90)
					kind = SK_SHORT_SUM;
				else if (pick < 94)
					kind = SK_STAR_IN_SUM;
				else
					kind = SK_NOISE;
				body_len = ($urandom_range(0, 9) == 0) ? $urandom_range(61, 120)
					: $urandom_range(0, 60);
				compose_sentence(kind, body_len, 1'b1);
				// hold the sender until the pipe is empty
				if (in_phase == 5 || $urandom_range(0, 15) == 0) begin
					drain_reports();
					pause_total++;
				end
				send_sentence();
				items += sentence_bytes.size();
				in_phase++;
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_register_reset();
		test_directed_sentences();
		test_length_limits();
		test_random_sentences();
		drain_reports();
		repeat (10) @(posedge clk);
		$display("covered %0d sentences in %0d bytes, %0d reports checked, %0d accepted",
			sentence_total, byte_total, reports_checked, accepted_seen);
		$display("min_length set %0d times from 0 to 255, sender held for drain %0d times",
			settings_total, pause_total);
		if (error_count == 0)
			$display("nmea_sentence_checksum_check regression: pass");
		else
			$display("nmea_sentence_checksum_check regression: fail");
		$finish;
	end

endmodule

/* nmea_sentence_checksum_check.f */
+incdir+design
design/nscc_pkg.sv
design/nscc_cfg.sv
design/nscc_core.sv
design/nmea_sentence_checksum_check.sv
tb/nmea_sentence_checksum_check_test.sv
